FILE: rtl/core/ssu_pkg.sv
package ssu_pkg;

   // Sizes of the search window and the byte counter
   localparam int PATTERN_MAX = 16;
   localparam int COUNT_BITS  = 32;
   localparam int LEN_BITS    = $clog2(PATTERN_MAX + 1);
   localparam int IDX_BITS    = $clog2(PATTERN_MAX);
   localparam int CSR_BITS    = 64;
   localparam int CSR_IDX_BITS = 2;

   // Register indexes of the control port
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef logic [PATTERN_MAX-1:0][7:0] window_type;

   // Pattern as seen by the compare logic, length already clamped
   typedef struct packed {
      window_type           bytes;
      logic [LEN_BITS-1:0]  length;
   } pattern_type;

endpackage

FILE: rtl/core/ssu_csr.sv
module ssu_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [ssu_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ssu_pkg::CSR_BITS-1:0]         csr_write_data,
   output ssu_pkg::pattern_type                 pattern
);

   logic [ssu_pkg::CSR_BITS-1:0]  pattern_low_ff;
   logic [ssu_pkg::CSR_BITS-1:0]  pattern_high_ff;
   logic [ssu_pkg::LEN_BITS-1:0]  pattern_length_ff;

   // Register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ssu_pkg::CSR_PATTERN_LOW:    pattern_low_ff    <= csr_write_data;
            ssu_pkg::CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_write_data;
            ssu_pkg::CSR_PATTERN_LENGTH:
               pattern_length_ff <= csr_write_data[ssu_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Byte k of the pattern sits in bits 8k+7..8k of {high, low}
   always_comb begin
      pattern.bytes = {pattern_high_ff, pattern_low_ff};
      if (pattern_length_ff > ssu_pkg::LEN_BITS'(ssu_pkg::PATTERN_MAX)) begin
         pattern.length = ssu_pkg::LEN_BITS'(ssu_pkg::PATTERN_MAX);
      end else begin
         pattern.length = pattern_length_ff;
      end
   end

endmodule

FILE: rtl/core/ssu_match.sv
module ssu_match (
   input  ssu_pkg::window_type   window,
   input  ssu_pkg::pattern_type  pattern,
   output logic                  match
);

   logic [ssu_pkg::PATTERN_MAX-1:0] byte_ok;

   // Pattern byte k lines up with window entry length-1-k (newest at 0)
   always_comb begin
      logic [ssu_pkg::LEN_BITS-1:0] idx;
      for (int k = 0; k < ssu_pkg::PATTERN_MAX; k++) begin
         idx = pattern.length - ssu_pkg::LEN_BITS'(k + 1);
         if (ssu_pkg::LEN_BITS'(k) < pattern.length) begin
            byte_ok[k] = (window[idx[ssu_pkg::IDX_BITS-1:0]] == pattern.bytes[k]);
         end else begin
            byte_ok[k] = 1'b1;
         end
      end
      match = &byte_ok;
   end

endmodule

FILE: rtl/core/substring_search_unit.sv
// Streaming substring search.
// Program the pattern over the csr_ port while idle: register 0 holds pattern
// bytes 0..7, register 1 bytes 8..15, register 2 the length (0 = empty,
// above 16 counts as 16). Text bytes arrive one per request on the req_
// channel; req_end_of_text closes a text, req_byte_valid low marks a request
// without a byte (a bare end marker if req_end_of_text is set). Each text gives
// exactly one response on rsp_: the start position of the first match as soon
// as it completes, or found low at the end of the text. An empty pattern
// answers position 0 on the first request. Throughput is one request per
// cycle while no response is held: the request register and the response
// register are each one stage, and the window compare sits between them.
// When rsp_ready is low with a response pending, the response is held and
// the request stage stalls once it is full, which drops req_ready. Reset
// clears the pattern registers, the window, the byte count and both stages.
module substring_search_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_text_byte,
   input  logic                                req_byte_valid,
   input  logic                                req_end_of_text,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [31:0]                         rsp_position,
   input  logic                                csr_write_enable,
   input  logic [ssu_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ssu_pkg::CSR_BITS-1:0]        csr_write_data
);

   ssu_pkg::pattern_type pattern;

   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_byte_valid_ff;
   logic        s1_last_ff;

   ssu_pkg::window_type               window_ff;
   ssu_pkg::window_type               window_in;
   logic [ssu_pkg::COUNT_BITS-1:0]    seen_ff;
   logic [ssu_pkg::COUNT_BITS-1:0]    seen_in;
   logic                              answered_ff;
   logic                              answered_in;

   logic                              rsp_valid_ff;
   logic                              rsp_found_ff;
   logic [ssu_pkg::COUNT_BITS-1:0]    rsp_position_ff;
   logic                              rsp_found_in;
   logic [ssu_pkg::COUNT_BITS-1:0]    rsp_position_in;

   logic advance;
   logic s1_fire;
   logic match;
   logic hit;
   logic empty_pat;
   logic has_res;

   ssu_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pattern          (pattern)
   );

   // Handshake: the request stage moves whenever the response slot frees
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_byte_ff       <= req_text_byte;
         s1_byte_valid_ff <= req_byte_valid;
         s1_last_ff       <= req_end_of_text;
      end
   end

   // Window shift and saturating byte count
   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      if (s1_byte_valid_ff) begin
         window_in = {window_ff[ssu_pkg::PATTERN_MAX-2:0], s1_byte_ff};
         if (seen_ff != ssu_pkg::COUNT_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   ssu_match u_match (
      .window  (window_in),
      .pattern (pattern),
      .match   (match)
   );

   // Response decision
   assign empty_pat = (pattern.length == '0);
   assign hit = s1_byte_valid_ff && match
              && (seen_in >= ssu_pkg::COUNT_BITS'(pattern.length));
   assign has_res = !answered_ff && (empty_pat || hit || s1_last_ff);

   always_comb begin
      rsp_found_in    = empty_pat || hit;
      rsp_position_in = '0;
      if (!empty_pat && hit) begin
         rsp_position_in = seen_in - ssu_pkg::COUNT_BITS'(pattern.length);
      end
      answered_in = answered_ff || has_res;
   end

   // Per-text state, cleared after the end of a text
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         seen_ff     <= '0;
         answered_ff <= 1'b0;
      end else if (s1_fire) begin
         if (s1_last_ff) begin
            window_ff   <= '0;
            seen_ff     <= '0;
            answered_ff <= 1'b0;
         end else begin
            window_ff   <= window_in;
            seen_ff     <= seen_in;
            answered_ff <= answered_in;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff && has_res;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && has_res) begin
         rsp_found_ff    <= rsp_found_in;
         rsp_position_ff <= rsp_position_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // Checks
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_position_ff == '0)
      else $error("not-found response carries a nonzero position");

   a_answer_sticks: assert property (@(posedge clock) disable iff (reset)
      s1_fire && has_res && !s1_last_ff |=> answered_ff)
      else $error("answer flag not set after a response");

   a_text_clears: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> seen_ff == '0 && !answered_ff)
      else $error("text state not cleared at end of text");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_fire && hit |-> seen_in >= ssu_pkg::COUNT_BITS'(pattern.length))
      else $error("match reported before enough bytes were seen");

endmodule

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Index with no register behind it; writes there must change nothing
   localparam logic [ssu_pkg::CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_BYTES    = 600;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       byte_valid;
      logic       end_of_text;
   } text_request_type;

   typedef struct packed {
      logic        found;
      logic [31:0] position;
   } search_result_type;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_EVERY_THIRD,
      READY_BURSTS
   } stall_mode_type;

   logic                             clock            = 1'b0;
   logic                             reset            = 1'b1;
   logic                             req_valid        = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_text_byte    = '0;
   logic                             req_byte_valid   = 1'b0;
   logic                             req_end_of_text  = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready        = 1'b0;
   logic                             rsp_found;
   logic [31:0]                      rsp_position;
   logic                             csr_write_enable = 1'b0;
   logic [ssu_pkg::CSR_IDX_BITS-1:0] csr_index        = '0;
   logic [ssu_pkg::CSR_BITS-1:0]     csr_write_data   = '0;

   substring_search_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_byte_valid   (req_byte_valid),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Search model state: registers, sliding window (newest byte at 0), text progress
   logic [63:0]                    model_pattern_low    = '0;
   logic [63:0]                    model_pattern_high   = '0;
   logic [4:0]                     model_pattern_length = '0;
   logic [7:0]                     window_bytes [ssu_pkg::PATTERN_MAX];
   logic [ssu_pkg::COUNT_BITS-1:0] text_count;
   logic                           text_answered;

   search_result_type expected_results [$];
   text_request_type  pending_requests [$];
   int                queued_count      = 0;
   int                accepted_count    = 0;
   int                mismatch_count    = 0;
   int                random_byte_count = 0;

   // Byte source for the current phase: a few symbols, or the full range
   logic [7:0] alphabet [4];
   bit         wide_alphabet = 1'b1;

   function automatic void clear_text();
      for (int i = 0; i < ssu_pkg::PATTERN_MAX; i++) window_bytes[i] = 8'h00;
      text_count    = '0;
      text_answered = 1'b0;
   endfunction

   function automatic int unsigned active_length();
      return (model_pattern_length > ssu_pkg::PATTERN_MAX) ? ssu_pkg::PATTERN_MAX
                                                           : model_pattern_length;
   endfunction

   // Advance the search by one request, queue the answer it produces if any
   function automatic void predict_search(input text_request_type item);
      int unsigned       len;
      logic [127:0]      pattern_bits;
      bit                hit;
      search_result_type result;
      len          = active_length();
      pattern_bits = {model_pattern_high, model_pattern_low};
      hit          = 1'b0;
      result       = '0;
      if (item.byte_valid) begin
         for (int i = ssu_pkg::PATTERN_MAX - 1; i > 0; i--)
            window_bytes[i] = window_bytes[i-1];
         window_bytes[0] = item.text_byte;
         if (text_count != ssu_pkg::COUNT_MAX) text_count++;
      end
      if (len != 0 && item.byte_valid && text_count >= len) begin
         hit = 1'b1;
         // pattern byte 0 lines up with the oldest byte of the window slice
         for (int k = 0; k < len; k++)
            if (window_bytes[len-1-k] != pattern_bits[8*k +: 8]) hit = 1'b0;
      end
      if (!text_answered) begin
         if (len == 0 || hit) begin
            result.found    = 1'b1;
            result.position = (len == 0) ? 32'd0 : 32'(text_count - len);
            text_answered   = 1'b1;
            expected_results.push_back(result);
         end else if (item.end_of_text) begin
            text_answered = 1'b1;
            expected_results.push_back(result);
         end
      end
      if (item.end_of_text) clear_text();
   endfunction

   // Request driver: bursts of random length with random gaps between them
   int               burst_left = 0;
   int               gap_left   = 0;
   text_request_type offered_request;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_search({req_text_byte, req_byte_valid, req_end_of_text});
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || pending_requests.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               offered_request = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_text_byte   <= offered_request.text_byte;
               req_byte_valid  <= offered_request.byte_valid;
               req_end_of_text <= offered_request.end_of_text;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Response backpressure: a random mode, redrawn each time its timer runs out
   stall_mode_type stall_mode  = READY_ALWAYS;
   int             stall_timer = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_timer = 0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode  = stall_mode_type'($urandom_range(0, 3));
            stall_timer = $urandom_range(20, 120);
         end else begin
            stall_timer--;
         end
         case (stall_mode)
            READY_ALWAYS:      rsp_ready <= 1'b1;
            READY_RANDOM:      rsp_ready <= 1'($urandom_range(0, 1));
            READY_EVERY_THIRD: rsp_ready <= (stall_timer % 3 == 0);
            default:           rsp_ready <= (stall_timer % 16 < 4);
         endcase
      end
   end

   // Response checker
   search_result_type oldest_result;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: found %0b position %0d", rsp_found, rsp_position);
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_found !== oldest_result.found || rsp_position !== oldest_result.position) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected found %0b position %0d, got found %0b position %0d",
                           oldest_result.found, oldest_result.position, rsp_found, rsp_position);
            end
         end
      end
   end

   task automatic push_item(input logic [7:0] text_byte, input logic byte_valid,
                            input logic end_of_text);
      pending_requests.push_back({text_byte, byte_valid, end_of_text});
      queued_count++;
   endtask

   task automatic write_register(input logic [ssu_pkg::CSR_IDX_BITS-1:0] index,
                                 input logic [ssu_pkg::CSR_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         ssu_pkg::CSR_PATTERN_LOW:    model_pattern_low    = data;
         ssu_pkg::CSR_PATTERN_HIGH:   model_pattern_high   = data;
         ssu_pkg::CSR_PATTERN_LENGTH: model_pattern_length = data[4:0];
         default: ;
      endcase
   endtask

   task automatic program_pattern(input logic [63:0] low_word, input logic [63:0] high_word,
                                  input logic [63:0] length_word, input bit poke_unused);
      write_register(ssu_pkg::CSR_PATTERN_LOW, low_word);
      write_register(ssu_pkg::CSR_PATTERN_HIGH, high_word);
      write_register(ssu_pkg::CSR_PATTERN_LENGTH, length_word);
      if (poke_unused) write_register(CSR_UNUSED, {$urandom, $urandom});
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Drain: everything sent, every answer back, then let the pipeline settle
   task automatic wait_idle();
      while (accepted_count != queued_count || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_text_byte();
      return wide_alphabet ? 8'($urandom_range(0, 255)) : alphabet[2'($urandom_range(0, 3))];
   endfunction

   // One text, usually with the pattern planted, sprinkled with bare markers
   task automatic add_random_text(input int unsigned text_len);
      int unsigned  plen;
      int unsigned  plant_at;
      bit           plant;
      bit           closed_by_marker;
      logic [127:0] pattern_bits;
      logic [7:0]   text_byte;
      plen             = active_length();
      pattern_bits     = {model_pattern_high, model_pattern_low};
      plant            = ($urandom_range(0, 9) < 6) && plen != 0 && plen <= text_len;
      plant_at         = plant ? $urandom_range(0, text_len - plen) : text_len;
      closed_by_marker = ($urandom_range(0, 4) == 0) || text_len == 0;
      for (int i = 0; i < text_len; i++) begin
         if ($urandom_range(0, 11) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         if (plant && i >= plant_at && i < plant_at + plen)
            text_byte = pattern_bits[8*(i-plant_at) +: 8];
         else
            text_byte = pick_text_byte();
         push_item(text_byte, 1'b1, (i == text_len - 1) && !closed_by_marker);
         random_byte_count++;
      end
      if (closed_by_marker) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Stimulus sequence
   initial begin
      logic [127:0] pattern_bits;
      int unsigned  pattern_len;
      logic [63:0]  length_word;
      clear_text();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset: empty pattern answers on the first request of each text,
      // a bare end marker included
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b1);
      push_item(8'h5A, 1'b0, 1'b1);
      wait_idle();

      // Single 0xFF byte: match mid-text then silence, miss closed by a bare marker,
      // plain miss
      program_pattern(64'h0000_0000_0000_00FF, 64'h0, 64'd1, 1'b0);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b1);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'h12, 1'b0, 1'b1);
      push_item(8'h00, 1'b1, 1'b1);
      wait_idle();

      // Full window, length field all ones (clamped to 16), unused index poked
      program_pattern('1, '0, '1, 1'b1);
      for (int i = 0; i < ssu_pkg::PATTERN_MAX; i++)
         push_item((i < 8) ? 8'hFF : 8'h00, 1'b1, i == ssu_pkg::PATTERN_MAX - 1);
      wait_idle();

      // Zero pattern must not match the cleared window before enough bytes arrive
      program_pattern('0, '0, 64'd3, 1'b0);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'h00, 1'b1, 1'b1);

      // Random phases, each with its own pattern and byte source
      while (random_byte_count < RANDOM_BYTES) begin
         wait_idle();
         wide_alphabet = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom_range(0, 255));
         for (int k = 0; k < ssu_pkg::PATTERN_MAX; k++) pattern_bits[8*k +: 8] = pick_text_byte();
         case ($urandom_range(0, 9))
            0:       pattern_len = 0;
            1:       pattern_len = $urandom_range(ssu_pkg::PATTERN_MAX + 1, 31);
            2:       pattern_len = ssu_pkg::PATTERN_MAX;
            default: pattern_len = $urandom_range(1, 8);
         endcase
         // upper bits of the length register are don't-care
         length_word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
         length_word[4:0] = pattern_len[4:0];
         program_pattern(pattern_bits[63:0], pattern_bits[127:64], length_word,
                         $urandom_range(0, 7) == 0);
         repeat ($urandom_range(3, 8))
            add_random_text(($urandom_range(0, 3) == 0) ? $urandom_range(17, 48)
                                                        : $urandom_range(0, 16));
      end

      wait_idle();
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("PASS substring_search_unit");
      else
         $display("FAIL substring_search_unit");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAIL substring_search_unit");
      $finish;
   end

endmodule
